### hdl/bb3_pkg.sv
// Shared constants, types and the reciprocal table for the 3x3 RGB box blur.
package bb3_pkg;

  localparam int MAX_WIDTH   = 2048;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int FILL_W      = COL_W + 1;
  localparam int FW_W        = 12;
  localparam int FH_W        = 13;
  localparam int CH_W        = 8;
  localparam int LANES       = 3;
  localparam int PIX_W       = CH_W * LANES;
  localparam int WIN_N       = 9;
  localparam int SUM_W       = 12;
  localparam int CNT_W       = 4;
  localparam int RECIP_SHIFT = 16;
  localparam int RECIP_W     = 17;
  localparam int CFG_A_W     = 2;
  localparam int CFG_D_W     = 13;

  localparam logic [CFG_A_W-1:0] CFG_FRAME_WIDTH  = CFG_A_W'(0);
  localparam logic [CFG_A_W-1:0] CFG_FRAME_HEIGHT = CFG_A_W'(1);

  localparam logic [FW_W-1:0] WIDTH_RESET  = FW_W'(640);
  localparam logic [FH_W-1:0] HEIGHT_RESET = FH_W'(480);

  typedef struct packed {
    logic sum_en;
    logic mul_en;
  } bb3_lane_ctrl_t;

  // ceil(2^16 / n): exact floor division for sums below 4096 and n up to 9
  function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] n);
    logic [RECIP_W-1:0] r;
    case (n)
      4'd2:    r = RECIP_W'(32768);
      4'd3:    r = RECIP_W'(21846);
      4'd4:    r = RECIP_W'(16384);
      4'd5:    r = RECIP_W'(13108);
      4'd6:    r = RECIP_W'(10923);
      4'd7:    r = RECIP_W'(9363);
      4'd8:    r = RECIP_W'(8192);
      4'd9:    r = RECIP_W'(7282);
      default: r = RECIP_W'(65536);
    endcase
    return r;
  endfunction

endpackage

### hdl/bb3_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bb3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### hdl/bb3_lane.sv
// One colour lane: masked sum of the 3x3 window, then divide by reciprocal multiply.
module bb3_lane (
  input  logic                          clk,
  input  bb3_pkg::bb3_lane_ctrl_t       ctrl,
  input  logic [bb3_pkg::CH_W-1:0]      chan [bb3_pkg::WIN_N],
  input  logic [bb3_pkg::WIN_N-1:0]     keep,
  input  logic [bb3_pkg::RECIP_W-1:0]   recip_val,
  output logic [bb3_pkg::CH_W-1:0]      mean
);
  import bb3_pkg::*;

  logic [SUM_W-1:0]         sum_nxt;
  logic [SUM_W-1:0]         sum_r;
  logic [SUM_W+RECIP_W-1:0] prod;
  logic [CH_W-1:0]          mean_r;

  always_comb begin
    sum_nxt = '0;
    for (int i = 0; i < WIN_N; i++) begin
      if (keep[i]) begin
        sum_nxt = sum_nxt + SUM_W'(chan[i]);
      end
    end
  end

  assign prod = (SUM_W+RECIP_W)'(sum_r) * (SUM_W+RECIP_W)'(recip_val);

  always_ff @(posedge clk) begin
    if (ctrl.sum_en) begin
      sum_r <= sum_nxt;
    end
    if (ctrl.mul_en) begin
      mean_r <= prod[RECIP_SHIFT +: CH_W];
    end
  end

  assign mean = mean_r;

endmodule

### hdl/box_blur_3x3_rgb_core.sv
// 3x3 RGB box blur: sequencer, line stores, window and merge of the colour lanes.
//
// Pixels enter in raster order on the in_ stream, one request each; in_tuser
// high marks a flush step that takes in a black pixel. After the frame's last
// pixel send frame_width + 1 flush steps to drain the rest. Each pixel or
// flush step after the first frame_width + 1 of a frame gives one result on
// the out_ stream; out_tlast marks the frame's final result.
// Frame size is set through cfg_we / cfg_addr / cfg_wdata (0 = width, 1 = height)
// by the user while the block is idle (not enforced); a size write restarts the frame.
// An item walks through a five-state sequencer: line store read, store write
// and window shift, lane sums, reciprocal multiply, output load. A request
// that gives a result is offered once the output load is done, and the next
// is taken only back in idle; a warm-up request returns to idle after the
// store write. The single line-store port pair per row sets that walk.
// The output register holds a result while out_tready is low; a new request
// is still accepted then, and the sequencer waits in its last state until
// the register frees up.
// Reset (rst_n low, synchronous) restores 640 x 480, clears positions and
// window; line store columns never written since reset read as black.
module box_blur_3x3_rgb_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [bb3_pkg::PIX_W-1:0]     in_tdata,   // red_in, green_in, blue_in
  input  logic                          in_tuser,   // command
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [bb3_pkg::PIX_W-1:0]     out_tdata,  // red_out, green_out, blue_out
  output logic                          out_tlast,
  input  logic                          cfg_we,
  input  logic [bb3_pkg::CFG_A_W-1:0]   cfg_addr,
  input  logic [bb3_pkg::CFG_D_W-1:0]   cfg_wdata
);
  import bb3_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_SUM,
    ST_MUL,
    ST_OUT
  } state_t;

  state_t             state_r, state_nxt;
  logic [FW_W-1:0]    width_r;
  logic [FH_W-1:0]    height_r;
  logic [COL_W-1:0]   in_col_r, in_col_nxt;
  logic [FH_W-1:0]    in_row_r, in_row_nxt;
  logic [COL_W-1:0]   out_col_r, out_col_nxt;
  logic [FH_W-1:0]    out_row_r, out_row_nxt;
  logic [FILL_W-1:0]  fill_r;
  logic [COL_W-1:0]   col_r;
  logic [PIX_W-1:0]   pix_r;
  logic               emit_r;
  logic [WIN_N-1:0]   keep_r, keep_nxt;
  logic               last_r, last_nxt;
  logic [RECIP_W-1:0] recip_r;
  logic [PIX_W-1:0]   win_r [3][3];
  logic               out_valid_r;
  logic [PIX_W-1:0]   out_data_r;
  logic               out_last_r;

  logic [31:0]        w_ext;
  logic [FILL_W-1:0]  eff_w;
  logic [FH_W-1:0]    eff_h;
  logic               accept;
  logic               emit;
  logic [FILL_W-1:0]  in_col_inc;
  logic [FILL_W-1:0]  out_col_inc;
  logic [FH_W:0]      out_row_inc;
  logic               oc_end, or_end;
  logic [2:0]         col_ok, row_ok;
  logic               out_free;
  logic               rd_ok;
  logic [PIX_W-1:0]   upper_rd, mid_rd, upper_q, mid_q;
  bb3_lane_ctrl_t     lane_ctrl;
  logic [CH_W-1:0]    lane_mean [LANES];

  // effective frame size
  always_comb begin
    w_ext = 32'(width_r);
    if (w_ext == 32'd0) begin
      eff_w = FILL_W'(1);
    end else if (w_ext > 32'(MAX_WIDTH)) begin
      eff_w = FILL_W'(MAX_WIDTH);
    end else begin
      eff_w = FILL_W'(w_ext);
    end
    eff_h = (height_r == '0) ? FH_W'(1) : height_r;
  end

  assign accept   = in_tvalid && in_tready;
  assign in_tready = (state_r == ST_IDLE);
  assign out_free = !out_valid_r || out_tready;

  // positions and neighbourhood mask, worked out when a request is taken
  always_comb begin
    in_col_inc  = FILL_W'(in_col_r) + FILL_W'(1);
    out_col_inc = FILL_W'(out_col_r) + FILL_W'(1);
    out_row_inc = (FH_W+1)'(out_row_r) + (FH_W+1)'(1);
    emit   = (in_row_r >= FH_W'(2)) || (in_row_r == FH_W'(1) && in_col_r != '0);
    oc_end = (out_col_inc >= eff_w);
    or_end = (out_row_inc >= (FH_W+1)'(eff_h));
    last_nxt = oc_end && or_end;
    col_ok = {!oc_end, 1'b1, out_col_r != '0};
    row_ok = {!or_end, 1'b1, out_row_r != '0};
    for (int k = 0; k < 3; k++) begin
      for (int r = 0; r < 3; r++) begin
        keep_nxt[k*3+r] = col_ok[k] && row_ok[r];
      end
    end

    if (in_col_inc >= eff_w) begin
      in_col_nxt = '0;
      in_row_nxt = (in_row_r != '1) ? in_row_r + FH_W'(1) : in_row_r;
    end else begin
      in_col_nxt = in_col_inc[COL_W-1:0];
      in_row_nxt = in_row_r;
    end

    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    if (emit) begin
      if (last_nxt) begin
        in_col_nxt  = '0;
        in_row_nxt  = '0;
        out_col_nxt = '0;
        out_row_nxt = '0;
      end else if (oc_end) begin
        out_col_nxt = '0;
        out_row_nxt = out_row_inc[FH_W-1:0];
      end else begin
        out_col_nxt = out_col_inc[COL_W-1:0];
      end
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (accept) state_nxt = ST_WRITE;
      ST_WRITE: state_nxt = emit_r ? ST_SUM : ST_IDLE;
      ST_SUM:   state_nxt = ST_MUL;
      ST_MUL:   state_nxt = ST_OUT;
      ST_OUT:   if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // line stores: columns at or beyond the fill mark have never been written
  assign rd_ok   = (FILL_W'(col_r) < fill_r);
  assign upper_q = rd_ok ? upper_rd : '0;
  assign mid_q   = rd_ok ? mid_rd : '0;

  bb3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper_ram (
    .clk     (clk),
    .wr_en   (state_r == ST_WRITE),
    .wr_addr (col_r),
    .wr_data (mid_q),
    .rd_en   (accept),
    .rd_addr (in_col_r),
    .rd_data (upper_rd)
  );

  bb3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_mid_ram (
    .clk     (clk),
    .wr_en   (state_r == ST_WRITE),
    .wr_addr (col_r),
    .wr_data (pix_r),
    .rd_en   (accept),
    .rd_addr (in_col_r),
    .rd_data (mid_rd)
  );

  assign lane_ctrl.sum_en = (state_r == ST_SUM);
  assign lane_ctrl.mul_en = (state_r == ST_MUL);

  for (genvar ln = 0; ln < LANES; ln++) begin : g_lane
    logic [CH_W-1:0] chan [WIN_N];

    always_comb begin
      for (int k = 0; k < 3; k++) begin
        for (int r = 0; r < 3; r++) begin
          chan[k*3+r] = win_r[k][r][(LANES-1-ln)*CH_W +: CH_W];
        end
      end
    end

    bb3_lane u_lane (
      .clk       (clk),
      .ctrl      (lane_ctrl),
      .chan      (chan),
      .keep      (keep_r),
      .recip_val (recip_r),
      .mean      (lane_mean[ln])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      width_r     <= WIDTH_RESET;
      height_r    <= HEIGHT_RESET;
      in_col_r    <= '0;
      in_row_r    <= '0;
      out_col_r   <= '0;
      out_row_r   <= '0;
      fill_r      <= '0;
      emit_r      <= 1'b0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        for (int r = 0; r < 3; r++) begin
          win_r[k][r] <= '0;
        end
      end
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        case (cfg_addr)
          CFG_FRAME_WIDTH: begin
            width_r   <= cfg_wdata[FW_W-1:0];
            in_col_r  <= '0;
            in_row_r  <= '0;
            out_col_r <= '0;
            out_row_r <= '0;
          end
          CFG_FRAME_HEIGHT: begin
            height_r  <= cfg_wdata[FH_W-1:0];
            in_col_r  <= '0;
            in_row_r  <= '0;
            out_col_r <= '0;
            out_row_r <= '0;
          end
          default: ;
        endcase
      end

      if (accept) begin
        in_col_r  <= in_col_nxt;
        in_row_r  <= in_row_nxt;
        out_col_r <= out_col_nxt;
        out_row_r <= out_row_nxt;
        emit_r    <= emit;
      end

      // shift the window left, take in the new column
      if (state_r == ST_WRITE) begin
        for (int r = 0; r < 3; r++) begin
          win_r[0][r] <= win_r[1][r];
          win_r[1][r] <= win_r[2][r];
        end
        win_r[2][0] <= upper_q;
        win_r[2][1] <= mid_q;
        win_r[2][2] <= pix_r;
        if (!rd_ok) begin
          fill_r <= FILL_W'(col_r) + FILL_W'(1);
        end
      end

      if (state_r == ST_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      col_r   <= in_col_r;
      pix_r   <= in_tuser ? '0 : {in_tdata[CH_W-1:0], in_tdata[2*CH_W-1:CH_W],
                                   in_tdata[3*CH_W-1:2*CH_W]};
      keep_r  <= keep_nxt;
      last_r  <= last_nxt;
      recip_r <= recip(CNT_W'($countones(keep_nxt)));
    end
    if (state_r == ST_OUT && out_free) begin
      out_data_r <= {lane_mean[2], lane_mean[1], lane_mean[0]};
      out_last_r <= last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

### test/blur_checker.sv
`timescale 1ns / 100ps
// Checker: predicts the blurred pixel stream from accepted requests and compares results.
module blur_checker #(
  parameter logic FLUSH_CMD = 1'b1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  input  logic                          in_tready,
  input  logic [bb3_pkg::PIX_W-1:0]     in_tdata,   // red_in, green_in, blue_in
  input  logic                          in_tuser,   // command
  input  logic                          out_tvalid,
  input  logic                          out_tready,
  input  logic [bb3_pkg::PIX_W-1:0]     out_tdata,  // red_out, green_out, blue_out
  input  logic                          out_tlast,
  input  logic                          cfg_we,
  input  logic [bb3_pkg::CFG_A_W-1:0]   cfg_addr,
  input  logic [bb3_pkg::CFG_D_W-1:0]   cfg_wdata,
  output int                            fail_count,
  output int                            pending
);
  import bb3_pkg::*;

  // red sits in the lowest byte of the stream word
  typedef struct packed {
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
  } rgb_t;

  typedef struct packed {
    logic frame_end;
    rgb_t pix;
  } blur_res_t;

  logic [FW_W-1:0] width_q;
  logic [FH_W-1:0] height_q;
  rgb_t            upper_line  [MAX_WIDTH];
  rgb_t            middle_line [MAX_WIDTH];
  rgb_t            win [3][3];   // [column: left..right][row: top..bottom]
  int              in_col, in_row, out_col, out_row;
  blur_res_t       blur_q [$];
  int              errs = 0;
  int              shown = 0;

  task automatic clear_pos();
    in_col  = 0;
    in_row  = 0;
    out_col = 0;
    out_row = 0;
  endtask

  task automatic blur_step(input logic cmd, input rgb_t px_in, output bit got,
                           output blur_res_t res);
    int   w, h, col;
    int   sum_r, sum_g, sum_b, cnt;
    rgb_t px, v;
    w = width_q;
    if (w == 0) w = 1;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    h = height_q;
    if (h == 0) h = 1;
    px  = (cmd == FLUSH_CMD) ? rgb_t'('0) : px_in;
    col = (in_col >= MAX_WIDTH) ? MAX_WIDTH - 1 : in_col;

    // shift the window left and take in the new column
    for (int r = 0; r < 3; r++) begin
      win[0][r] = win[1][r];
      win[1][r] = win[2][r];
    end
    win[2][0] = upper_line[col];
    win[2][1] = middle_line[col];
    win[2][2] = px;
    upper_line[col]  = middle_line[col];
    middle_line[col] = px;

    got = (in_row >= 2) || (in_row == 1 && in_col >= 1);
    in_col++;
    if (in_col >= w) begin
      in_col = 0;
      if (in_row < 'h1FFF) in_row++;
    end

    res = '0;
    if (got) begin
      sum_r = 0;
      sum_g = 0;
      sum_b = 0;
      cnt   = 0;
      // leave out neighbours beyond the frame edges
      for (int k = 0; k < 3; k++) begin
        for (int r = 0; r < 3; r++) begin
          if ((k > 0 || out_col > 0) && (k < 2 || out_col + 1 < w) &&
              (r > 0 || out_row > 0) && (r < 2 || out_row + 1 < h)) begin
            v = win[k][r];
            sum_r += v.red;
            sum_g += v.green;
            sum_b += v.blue;
            cnt++;
          end
        end
      end
      res.pix.red   = CH_W'(sum_r / cnt);
      res.pix.green = CH_W'(sum_g / cnt);
      res.pix.blue  = CH_W'(sum_b / cnt);
      res.frame_end = (out_row + 1 >= h) && (out_col + 1 >= w);
      if (res.frame_end) begin
        clear_pos();
      end else begin
        out_col++;
        if (out_col >= w) begin
          out_col = 0;
          out_row++;
        end
      end
    end
  endtask

  always @(posedge clk) begin : watch
    bit        got;
    blur_res_t res;
    blur_res_t want;
    rgb_t      seen;
    if (!rst_n) begin
      width_q  = WIDTH_RESET;
      height_q = HEIGHT_RESET;
      for (int i = 0; i < MAX_WIDTH; i++) begin
        upper_line[i]  = '0;
        middle_line[i] = '0;
      end
      for (int k = 0; k < 3; k++)
        for (int r = 0; r < 3; r++)
          win[k][r] = '0;
      clear_pos();
      blur_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        seen = rgb_t'(out_tdata);
        if (blur_q.size() == 0) begin
          errs++;
          if (shown < 10)
            $display("unexpected result: r=%02h g=%02h b=%02h last=%0d",
                     seen.red, seen.green, seen.blue, out_tlast);
          shown++;
        end else begin
          want = blur_q.pop_front();
          if (seen.red !== want.pix.red || seen.green !== want.pix.green ||
              seen.blue !== want.pix.blue || out_tlast !== want.frame_end) begin
            errs++;
            if (shown < 10)
              $display("mismatch: expected r=%02h g=%02h b=%02h last=%0d, got r=%02h g=%02h b=%02h last=%0d",
                       want.pix.red, want.pix.green, want.pix.blue, want.frame_end,
                       seen.red, seen.green, seen.blue, out_tlast);
            shown++;
          end
        end
      end
      if (cfg_we) begin
        if (cfg_addr == CFG_FRAME_WIDTH) begin
          width_q = cfg_wdata[FW_W-1:0];
          clear_pos();
        end else if (cfg_addr == CFG_FRAME_HEIGHT) begin
          height_q = cfg_wdata[FH_W-1:0];
          clear_pos();
        end
      end
      if (in_tvalid && in_tready) begin
        blur_step(in_tuser, rgb_t'(in_tdata), got, res);
        if (got) blur_q.push_back(res);
      end
    end
    fail_count <= errs;
    pending    <= blur_q.size();
  end

endmodule

### test/tb.sv
`timescale 1ns / 100ps
// Testbench top: drives frames and frame-size writes into the box blur and gives the verdict.
module tb;
  import bb3_pkg::*;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;
  localparam logic [CFG_A_W-1:0] CFG_SPARE_LO = CFG_A_W'(2);
  localparam logic [CFG_A_W-1:0] CFG_SPARE_HI = CFG_A_W'(3);

  localparam int RANDOM_ITEMS  = 1500;
  localparam int CALM_ITEMS    = 200;
  localparam int SETTLE_CYCLES = 20;
  localparam int LONG_HOLD     = 300;
  localparam int QUIET_LIMIT   = 4000;

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [PIX_W-1:0]    in_tdata;
  logic                in_tuser;
  logic                out_tvalid;
  logic                out_tready;
  logic [PIX_W-1:0]    out_tdata;
  logic                out_tlast;
  logic                cfg_we;
  logic [CFG_A_W-1:0]  cfg_addr;
  logic [CFG_D_W-1:0]  cfg_wdata;
  int                  fail_count;
  int                  pending;

  bit idle_on   = 1'b1;
  bit long_hold = 1'b0;
  int sent       = 0;
  int hold_mark  = -1;
  int pause_mark = -1;
  int calm_mark  = -1;
  int quiet      = 0;

  box_blur_3x3_rgb_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  blur_checker #(.FLUSH_CMD(CMD_FLUSH)) blur_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin
    out_tready = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
        long_hold = 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 4) - 1) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
        quiet <= 0;
      else
        quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("FAIL box_blur_3x3_rgb_core");
        $finish;
      end
    end
  end

  // lower the request line, wait for every result, then let the pipeline drain
  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic push(input logic cmd, input logic [PIX_W-1:0] data);
    if (sent == pause_mark) settle();
    if (sent == hold_mark) long_hold = 1'b1;
    if (sent == calm_mark) idle_on = 1'b0;
    sent++;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4) - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= data;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic write_reg(input logic [CFG_A_W-1:0] addr, input logic [CFG_D_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // whole frame of w x h, a few black flush pixels inside, then the drain
  task automatic send_frame(input int w, input int h);
    for (int i = 0; i < w * h; i++)
      push(($urandom_range(0, 29) == 0) ? CMD_FLUSH : CMD_PIXEL, PIX_W'($urandom));
    for (int i = 0; i <= w; i++)
      push(($urandom_range(0, 9) == 0) ? CMD_PIXEL : CMD_FLUSH, PIX_W'($urandom));
  endtask

  initial begin
    int base, wr_w, wr_h, w, h, mode;
    in_tvalid = 1'b0;
    in_tuser  = CMD_PIXEL;
    in_tdata  = '0;
    cfg_we    = 1'b0;
    cfg_addr  = CFG_FRAME_WIDTH;
    cfg_wdata = '0;
    rst_n     = 1'b0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // reset size 640 x 480: all warm-up, no results
    push(CMD_PIXEL, 24'hFFFFFF);
    push(CMD_FLUSH, 24'hFFFFFF);
    push(CMD_PIXEL, 24'h000000);
    push(CMD_PIXEL, 24'hA5A5A5);
    settle();

    // 3 x 2: extremes, a flush inside the frame, a pixel during the drain
    write_reg(CFG_FRAME_WIDTH, CFG_D_W'(3));
    write_reg(CFG_FRAME_HEIGHT, CFG_D_W'(2));
    push(CMD_PIXEL, 24'hFFFFFF);
    push(CMD_PIXEL, 24'h000000);
    push(CMD_PIXEL, 24'h0000FF);
    push(CMD_PIXEL, 24'hFF0000);
    push(CMD_FLUSH, 24'h5A5A5A);
    push(CMD_PIXEL, 24'h00FF00);
    push(CMD_FLUSH, 24'hFFFFFF);
    push(CMD_FLUSH, 24'h123456);
    push(CMD_PIXEL, 24'hFFFFFF);
    push(CMD_FLUSH, 24'h000000);
    settle();

    // zero sizes act as a single pixel
    write_reg(CFG_FRAME_WIDTH, CFG_D_W'(0));
    write_reg(CFG_FRAME_HEIGHT, CFG_D_W'(0));
    push(CMD_PIXEL, 24'hFFFFFF);
    push(CMD_FLUSH, 24'hFFFFFF);
    push(CMD_FLUSH, 24'h000000);
    settle();

    // spare indexes are ignored; the top width bit is dropped
    write_reg(CFG_SPARE_LO, CFG_D_W'(5));
    write_reg(CFG_SPARE_HI, CFG_D_W'(13'h1FFF));
    write_reg(CFG_FRAME_WIDTH, CFG_D_W'(13'h1003));
    write_reg(CFG_FRAME_HEIGHT, CFG_D_W'(1));
    push(CMD_PIXEL, 24'hFFFFFF);
    push(CMD_PIXEL, 24'h010203);
    push(CMD_PIXEL, 24'hFEFDFC);
    repeat (4) push(CMD_FLUSH, PIX_W'($urandom));
    settle();

    // tallest setting the register holds
    write_reg(CFG_FRAME_HEIGHT, CFG_D_W'(8191));
    write_reg(CFG_FRAME_WIDTH, CFG_D_W'(5));
    repeat (60) push(CMD_PIXEL, PIX_W'($urandom));

    // random small frames, mostly well formed
    base       = sent;
    hold_mark  = base + 400;
    pause_mark = base + 800;
    calm_mark  = base + RANDOM_ITEMS - CALM_ITEMS;
    while (sent - base < RANDOM_ITEMS) begin
      settle();
      wr_w = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
      wr_h = $urandom_range(0, 6);
      w = (wr_w == 0) ? 1 : wr_w;
      h = (wr_h == 0) ? 1 : wr_h;
      if ($urandom_range(0, 5) == 0)
        write_reg($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI, CFG_D_W'($urandom));
      if ($urandom_range(0, 1)) begin
        write_reg(CFG_FRAME_WIDTH, CFG_D_W'(wr_w));
        write_reg(CFG_FRAME_HEIGHT, CFG_D_W'(wr_h));
      end else begin
        write_reg(CFG_FRAME_HEIGHT, CFG_D_W'(wr_h));
        write_reg(CFG_FRAME_WIDTH, CFG_D_W'(wr_w));
      end
      repeat ($urandom_range(1, 3)) begin
        mode = $urandom_range(0, 9);
        if (mode < 8) begin
          send_frame(w, h);
        end else if (mode == 8) begin
          // broken frame: cut short, then a ragged drain
          repeat ($urandom_range(0, w * h)) push(CMD_PIXEL, PIX_W'($urandom));
          repeat ($urandom_range(0, w + 2)) push(CMD_FLUSH, PIX_W'($urandom));
        end else begin
          repeat ($urandom_range(1, 2 * w + 2))
            push(1'($urandom_range(0, 1)), PIX_W'($urandom));
        end
      end
    end

    settle();
    if (fail_count == 0 && pending == 0) begin
      $display("PASS box_blur_3x3_rgb_core");
    end else begin
      $display("FAIL box_blur_3x3_rgb_core");
    end
    $finish;
  end

endmodule
